// File: hw/rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  // Capacity of the queue; CNT_W and AW are derived from it.
  localparam int DEPTH     = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int CNT_OUT_W = 5;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // Stream payload widths, padded to whole bytes.
  localparam int S_TDATA_W = ((IDX_W + DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + CNT_OUT_W + 7) / 8) * 8;
  localparam int OP_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE_AT  = 3'd4,
    OP_GET        = 3'd5,
    OP_SET        = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

// File: hw/rtl/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output bdq_pkg::cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  state_t state;

  // Execute in the same edge the item is taken.
  assign cmd.exec = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            state    <= ST_RESP;
            s_tready <= 1'b0;
            m_tvalid <= 1'b1;
          end else begin
            s_tready <= 1'b1;
          end
        end
        ST_RESP: begin
          if (m_tready) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          s_tready <= 1'b0;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (m_tvalid && state == ST_RESP))
    else $error("accepted item produced no result");

  a_taken_reopens: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
    else $error("input not reopened after result was taken");

endmodule

// File: hw/rtl/bdq_datapath.sv
`timescale 1ns / 1ps

module bdq_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  bdq_pkg::cmd_t                     cmd,
  input  bdq_pkg::op_t                      op,
  input  logic [bdq_pkg::IDX_W-1:0]         idx,
  input  logic [bdq_pkg::DATA_W-1:0]        val,
  output logic                              res_status,
  output logic [bdq_pkg::DATA_W-1:0]        res_value,
  output logic [bdq_pkg::CNT_OUT_W-1:0]     res_count
);

  logic [bdq_pkg::DATA_W-1:0] cells      [bdq_pkg::DEPTH];
  logic [bdq_pkg::DATA_W-1:0] cells_next [bdq_pkg::DEPTH];
  logic [bdq_pkg::CNT_W-1:0]  cnt;
  logic [bdq_pkg::CNT_W-1:0]  cnt_next;
  logic [bdq_pkg::CMP_W-1:0]  cnt_c;
  logic [bdq_pkg::CMP_W-1:0]  idx_c;
  logic [bdq_pkg::AW-1:0]     rd_addr;
  logic                       full;
  logic                       empty;
  logic                       in_range;
  logic                       status_next;
  logic [bdq_pkg::DATA_W-1:0] value_next;

  assign cnt_c    = bdq_pkg::CMP_W'(cnt);
  assign idx_c    = bdq_pkg::CMP_W'(idx);
  assign full     = (cnt == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign empty    = (cnt == '0);
  // cnt never exceeds DEPTH, so idx below cnt is also a valid cell.
  assign in_range = (idx_c < cnt_c);
  assign rd_addr  = bdq_pkg::AW'(idx_c);

  // Per-cell next value: each cell sees only its neighbors.
  for (genvar g = 0; g < bdq_pkg::DEPTH; g++) begin : g_cell
    localparam logic [bdq_pkg::CMP_W-1:0] POS = bdq_pkg::CMP_W'(g);
    logic [bdq_pkg::DATA_W-1:0] from_prev;
    logic [bdq_pkg::DATA_W-1:0] from_next;

    if (g == 0) begin : g_first
      assign from_prev = val;
    end else begin : g_mid_prev
      assign from_prev = cells[g-1];
    end

    if (g == bdq_pkg::DEPTH - 1) begin : g_last
      assign from_next = cells[g];
    end else begin : g_mid_next
      assign from_next = cells[g+1];
    end

    always_comb begin
      cells_next[g] = cells[g];
      case (op)
        bdq_pkg::OP_PUSH_FRONT: if (!full) cells_next[g] = from_prev;
        bdq_pkg::OP_PUSH_BACK:  if (!full && POS == cnt_c) cells_next[g] = val;
        bdq_pkg::OP_POP_FRONT:  if (!empty) cells_next[g] = from_next;
        bdq_pkg::OP_REMOVE_AT:  if (in_range && POS >= idx_c) cells_next[g] = from_next;
        bdq_pkg::OP_SET:        if (in_range && POS == idx_c) cells_next[g] = val;
        default:                cells_next[g] = cells[g];
      endcase
    end
  end

  always_comb begin
    cnt_next    = cnt;
    status_next = 1'b0;
    value_next  = '0;
    case (op)
      bdq_pkg::OP_PUSH_FRONT,
      bdq_pkg::OP_PUSH_BACK: begin
        if (full) status_next = 1'b1;
        else      cnt_next    = cnt + 1'b1;
      end
      bdq_pkg::OP_POP_FRONT,
      bdq_pkg::OP_POP_BACK: begin
        if (empty) status_next = 1'b1;
        else       cnt_next    = cnt - 1'b1;
      end
      bdq_pkg::OP_REMOVE_AT: begin
        if (!in_range) status_next = 1'b1;
        else           cnt_next    = cnt - 1'b1;
      end
      bdq_pkg::OP_GET: begin
        if (!in_range) begin
          status_next = 1'b1;
          value_next  = '1;
        end else begin
          value_next  = cells[rd_addr];
        end
      end
      bdq_pkg::OP_SET: begin
        if (!in_range) status_next = 1'b1;
      end
      bdq_pkg::OP_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.exec) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
        cells[i] <= cells_next[i];
      end
      res_status <= status_next;
      res_value  <= value_next;
      res_count  <= bdq_pkg::CNT_OUT_W'(cnt_next);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op == bdq_pkg::OP_CLEAR) |=> (cnt == '0 && res_count == '0))
    else $error("clear left entries behind");

  a_get_miss: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op == bdq_pkg::OP_GET && !in_range) |=> (res_status && res_value == '1))
    else $error("out-of-range get did not report minus one");

endmodule

// File: hw/rtl/bounded_deque_with_indexed_access.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values with indexed access.
// Input channel (s_*): one item per operation; s_tuser carries the op code
// (push front/back, pop front/back, remove at, get, set, clear), s_tdata the
// index and the value. Output channel (m_*): exactly one result item per
// input item, with status in m_tuser and read value plus count in m_tdata.
// Timing: the operation executes at the edge the item is taken and the
// result is valid the next cycle. The controller's two-state handshake
// alternates an accept state and a result state, so a new item is taken
// only after the pending result is delivered. Every op, remove at index
// included, executes at the accepting edge because all cells shift in parallel.
// Reset (rst, synchronous): count clears to zero, s_tready stays low through
// reset and the first cycle after it, no result pending. Cell contents stay
// undefined until written.
// Stall: while m_tready is low the result holds and s_tready stays low, so
// no further item is taken until the pending result is delivered.
module bounded_deque_with_indexed_access (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [3:0] index, [35:4] value, [39:36] zero
  input  logic [bdq_pkg::S_TDATA_W-1:0]   s_tdata,
  // [2:0] operation
  input  logic [bdq_pkg::OP_W-1:0]        s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] read_value, [36:32] count, [39:37] zero
  output logic [bdq_pkg::M_TDATA_W-1:0]   m_tdata,
  // [0] status
  output logic                            m_tuser
);

  bdq_pkg::cmd_t                  cmd;
  logic [bdq_pkg::DATA_W-1:0]     res_value;
  logic [bdq_pkg::CNT_OUT_W-1:0]  res_count;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Unpack the item and hand it to the cell row.
  bdq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (bdq_pkg::op_t'(s_tuser)),
    .idx        (s_tdata[bdq_pkg::IDX_W-1:0]),
    .val        (s_tdata[bdq_pkg::IDX_W +: bdq_pkg::DATA_W]),
    .res_status (m_tuser),
    .res_value  (res_value),
    .res_count  (res_count)
  );

  // Pack the result; pad bits stay zero.
  assign m_tdata = bdq_pkg::M_TDATA_W'({res_count, res_value});

endmodule

// File: verif/tb_bounded_deque_with_indexed_access.sv
`timescale 1ns / 1ps

module tb_bounded_deque_with_indexed_access;
  import bdq_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 650;
  localparam int REPORT_MAX = 10;

  // One result item as the block reports it.
  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] read_value;
    logic [4:0]        count;
  } deque_result_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [OP_W-1:0]      s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  // Shadow copy of the queue contents and fill level.
  logic [DATA_W-1:0] shadow_cells [DEPTH];
  int                shadow_count;

  deque_result_t pending_results[$];

  // Suppress random idling on both sides while set.
  bit steady;

  int cycles;
  int mismatches;
  int results_checked;
  int items_sent;
  int items_refused;
  int ops_sent [8];

  bounded_deque_with_indexed_access DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_CLEAR;
    m_tready = 1'b0;
  end

  always #HALF_PERIOD clk = ~clk;

  // Apply one operation to the shadow queue and return the result it must produce.
  function automatic deque_result_t apply_op(op_t op, logic [IDX_W-1:0] idx,
                                             logic [DATA_W-1:0] val);
    deque_result_t r;
    logic hit;
    int i;
    r.status = 1'b0;
    r.read_value = '0;
    hit = (int'(idx) < shadow_count);
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          for (i = shadow_count; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[0] = val;
          shadow_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          shadow_cells[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = 1'b1;
        end else begin
          for (i = 0; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_count--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) r.status = 1'b1;
        else shadow_count--;
      end
      OP_REMOVE_AT: begin
        if (!hit) begin
          r.status = 1'b1;
        end else begin
          for (i = int'(idx); i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_count--;
        end
      end
      OP_GET: begin
        if (!hit) begin
          r.status = 1'b1;
          r.read_value = '1;
        end else begin
          r.read_value = shadow_cells[idx];
        end
      end
      OP_SET: begin
        if (!hit) r.status = 1'b1;
        else shadow_cells[idx] = val;
      end
      default: shadow_count = 0;
    endcase
    r.count = 5'(shadow_count);
    return r;
  endfunction

  // Random value, biased toward the extremes of the signed range.
  function automatic logic [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Index that mostly lands inside the occupied range.
  function automatic logic [IDX_W-1:0] draw_index();
    if (shadow_count > 0 && $urandom_range(0, 9) < 8)
      return IDX_W'($urandom_range(0, shadow_count - 1));
    return IDX_W'($urandom_range(0, 15));
  endfunction

  // Offer one item on the input stream; called just after a falling edge.
  // Valid stays high on return so back-to-back items need no gap.
  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    deque_result_t want;
    while (!steady && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_TDATA_W - IDX_W - DATA_W){1'b0}}, val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // Item taken at this edge: update the shadow and queue the result.
    want = apply_op(op, idx, val);
    pending_results.push_back(want);
    items_sent++;
    ops_sent[op]++;
    if (want.status) items_refused++;
    @(negedge clk);
  endtask

  // Receiver backpressure: random stalls except during the steady stretch.
  always @(negedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 8);
  end

  // Compare every delivered result with the oldest waiting one.
  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status     = m_tuser;
      got.read_value = m_tdata[DATA_W-1:0];
      got.count      = m_tdata[DATA_W+4:DATA_W];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] unexpected result: status=%0b read=%h count=%0d",
                   $realtime, got.status, got.read_value, got.count);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: expected status=%0b read=%h count=%0d,",
                     $realtime, want.status, want.read_value, want.count,
                     " got status=%0b read=%h count=%0d",
                     got.status, got.read_value, got.count);
        end
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still waiting",
               cycles, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Refusals on an empty queue, then a short walk through every operation.
  task automatic test_empty_and_basic();
    send_item(OP_GET,        4'd0,  32'h1234_5678);
    send_item(OP_POP_FRONT,  4'd0,  32'h0);
    send_item(OP_POP_BACK,   4'd15, 32'h0);
    send_item(OP_REMOVE_AT,  4'd0,  32'h0);
    send_item(OP_SET,        4'd0,  32'hFFFF_FFFF);
    send_item(OP_CLEAR,      4'd15, 32'hFFFF_FFFF);
    send_item(OP_PUSH_FRONT, 4'd15, 32'h7FFF_FFFF);
    send_item(OP_PUSH_BACK,  4'd0,  32'h8000_0000);
    send_item(OP_PUSH_FRONT, 4'd5,  32'h0000_0000);
    send_item(OP_GET,        4'd0,  32'h0);
    send_item(OP_GET,        4'd2,  32'h0);
    send_item(OP_GET,        4'd3,  32'h0);
    send_item(OP_SET,        4'd1,  32'hFFFF_FFFF);
    send_item(OP_SET,        4'd15, 32'h5555_AAAA);
    send_item(OP_GET,        4'd1,  32'h0);
    send_item(OP_REMOVE_AT,  4'd1,  32'h0);
    send_item(OP_REMOVE_AT,  4'd2,  32'h0);
    send_item(OP_GET,        4'd1,  32'h0);
    send_item(OP_POP_FRONT,  4'd0,  32'h0);
    send_item(OP_POP_BACK,   4'd0,  32'h0);
    send_item(OP_CLEAR,      4'd0,  32'h0);
    send_item(OP_GET,        4'd15, 32'h0);
  endtask

  // Fill to capacity, hit the refusal and top-index cases, then drain.
  task automatic test_full_queue();
    send_item(OP_CLEAR, draw_index(), draw_value());
    while (shadow_count < DEPTH)
      send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                IDX_W'($urandom()), draw_value());
    send_item(OP_PUSH_FRONT, 4'd0,  draw_value());
    send_item(OP_PUSH_BACK,  4'd15, draw_value());
    send_item(OP_GET,        4'd15, 32'h0);
    send_item(OP_SET,        4'd15, 32'h8000_0000);
    send_item(OP_GET,        4'd15, 32'h0);
    send_item(OP_REMOVE_AT,  4'd15, 32'h0);
    send_item(OP_GET,        4'd15, 32'h0);
    send_item(OP_PUSH_BACK,  4'd0,  32'h7FFF_FFFF);
    send_item(OP_REMOVE_AT,  4'd0,  32'h0);
    send_item(OP_PUSH_FRONT, 4'd0,  draw_value());
    while (shadow_count > 0) begin
      case ($urandom_range(0, 3))
        0: send_item(OP_POP_FRONT, IDX_W'($urandom()), draw_value());
        1: send_item(OP_POP_BACK,  IDX_W'($urandom()), draw_value());
        2: send_item(OP_REMOVE_AT, draw_index(), draw_value());
        default: send_item(OP_GET, draw_index(), draw_value());
      endcase
    end
    send_item(OP_POP_FRONT, 4'd0, 32'h0);
  endtask

  // Random traffic in alternating grow, shrink and balanced phases so the
  // fill level sweeps between empty and full.
  task automatic test_random_traffic();
    int n;
    int phase;
    int roll;
    int push_cut;
    int pop_cut;
    op_t op;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 70) % 3;
      steady = (n >= 250 && n < 370);
      case (phase)
        0: begin push_cut = 60; pop_cut = 72; end
        1: begin push_cut = 15; pop_cut = 65; end
        default: begin push_cut = 35; pop_cut = 65; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_cut)
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else if (roll < pop_cut)
        op = op_t'($urandom_range(OP_POP_FRONT, OP_REMOVE_AT));
      else if (roll < 97)
        op = $urandom_range(0, 1) ? OP_GET : OP_SET;
      else
        op = op_t'($urandom_range(0, 7));
      send_item(op, draw_index(), draw_value());
    end
    steady = 1'b0;
  endtask

  initial begin
    steady = 1'b0;
    cycles = 0;
    mismatches = 0;
    results_checked = 0;
    items_sent = 0;
    items_refused = 0;
    foreach (ops_sent[i]) ops_sent[i] = 0;
    shadow_count = 0;

    // Hold reset, then release it on a falling edge.
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_and_basic();
    test_full_queue();
    test_random_traffic();

    // Drop valid, wait for the last results, then watch for stray ones.
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d items (%0d refused), checked %0d results in %0d cycles",
             items_sent, items_refused, results_checked, cycles);
    $display("Ops: pushF=%0d pushB=%0d popF=%0d popB=%0d remove=%0d get=%0d set=%0d clear=%0d",
             ops_sent[OP_PUSH_FRONT], ops_sent[OP_PUSH_BACK], ops_sent[OP_POP_FRONT],
             ops_sent[OP_POP_BACK], ops_sent[OP_REMOVE_AT], ops_sent[OP_GET],
             ops_sent[OP_SET], ops_sent[OP_CLEAR]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_datapath.sv
hw/rtl/bounded_deque_with_indexed_access.sv
verif/tb_bounded_deque_with_indexed_access.sv
